// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the free block pool RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error(msg);
// An antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/scfbp_pkg.sv -----
// Package of the size class free block pool: sizing constants, codes and word types.
// Used by scfbp_stack_mem and size_class_free_block_pool_core; depends on nothing.
package scfbp_pkg;

	localparam int unsigned ALIGN_BYTES = 8;
	localparam int unsigned CHUNK_BYTES = 4096;
	localparam int unsigned POOL_DEPTH  = 1024;
	localparam int unsigned MAX_BATCH   = 64;

	localparam int unsigned IDX_W   = $clog2(POOL_DEPTH);
	localparam int unsigned CNT_W   = $clog2(POOL_DEPTH + 1);
	localparam int unsigned BATCH_W = $clog2(MAX_BATCH + 1);
	localparam int unsigned NBLK_W  = $clog2(CHUNK_BYTES / ALIGN_BYTES + 1);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

	// Whole blocks in one chunk for each of the sixteen size classes.
	localparam int unsigned CARVE_BLOCKS [16] = '{
		CHUNK_BYTES / (1 * ALIGN_BYTES),  CHUNK_BYTES / (2 * ALIGN_BYTES),
		CHUNK_BYTES / (3 * ALIGN_BYTES),  CHUNK_BYTES / (4 * ALIGN_BYTES),
		CHUNK_BYTES / (5 * ALIGN_BYTES),  CHUNK_BYTES / (6 * ALIGN_BYTES),
		CHUNK_BYTES / (7 * ALIGN_BYTES),  CHUNK_BYTES / (8 * ALIGN_BYTES),
		CHUNK_BYTES / (9 * ALIGN_BYTES),  CHUNK_BYTES / (10 * ALIGN_BYTES),
		CHUNK_BYTES / (11 * ALIGN_BYTES), CHUNK_BYTES / (12 * ALIGN_BYTES),
		CHUNK_BYTES / (13 * ALIGN_BYTES), CHUNK_BYTES / (14 * ALIGN_BYTES),
		CHUNK_BYTES / (15 * ALIGN_BYTES), CHUNK_BYTES / (16 * ALIGN_BYTES)
	};

	localparam logic [1:0] FUNC_RELEASE = 2'd0;
	localparam logic [1:0] FUNC_TAKE    = 2'd1;
	localparam logic [1:0] FUNC_BATCH   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

	localparam logic [1:0] CFG_SIZE_CLASS = 2'd0;
	localparam logic [1:0] CFG_HEAP_BASE  = 2'd1;
	localparam logic [1:0] CFG_HEAP_END   = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] block_address;
		logic [6:0]  batch_count;
	} in_word_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0]  status;
		logic        last;
		logic [10:0] free_count;
		logic        pool_empty;
	} out_word_t;

	// One access request to the free stack memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [31:0]      wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REL,
		ST_ZERO,
		ST_REFILL_CHK,
		ST_REFILL,
		ST_POP_START,
		ST_POP_RD,
		ST_POP_OUT,
		ST_FAIL
	} state_t;

endpackage

// ----- rtl/scfbp_stack_mem.sv -----
// Free stack memory of the block pool: one write port, one registered read port.
// Depends on scfbp_pkg for depth, index width and the request struct.
module scfbp_stack_mem (
	input  logic               clk,
	input  scfbp_pkg::mem_req_t req,
	output logic [31:0]        rdata
);

	logic [31:0] mem [scfbp_pkg::POOL_DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/size_class_free_block_pool_core.sv -----
// Top level of the size class free block pool: sequencer, registers and output stage.
// Depends on scfbp_pkg, scfbp_stack_mem and assert_macros.svh.

// The pool is a last-in-first-out stack of free block addresses for one size class,
// kept in a single-port-write, registered-read memory of POOL_DEPTH words. One word is
// handled at a time. A release is accepted, then pushed with its result. A take of one
// block, when the pool holds a block, passes through accept, a count check, a memory
// read and the result. A batch of n blocks does a memory read and a result for each
// block, plus the closing exhausted word when it runs short. When the pool holds too
// few blocks, a refill first checks the heap bound. A chunk that fits is then carved
// with a separate memory write for every carved address, and a closing step ends the
// carve; that is up to CHUNK_BYTES divided by the block size carved blocks (512 at the
// smallest class). A stalled result holds the sequencer before it loads the next one.
// There is no clearing pass: only entries below the fill count are ever read.
// Configuration writes must be issued while the pool is idle; writing heap_base also
// rewinds the carve pointer.
module size_class_free_block_pool_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  scfbp_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output scfbp_pkg::out_word_t out_word,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

`include "assert_macros.svh"

	// Configuration registers.
	logic [3:0]  size_class_q;
	logic [31:0] heap_end_q;

	// Pool state and sequencer registers.
	scfbp_pkg::state_t                 state_q, state_d;
	logic [scfbp_pkg::CNT_W-1:0]       count_q;
	logic [31:0]                       next_chunk_q;
	logic [31:0]                       carve_addr_q;
	logic [scfbp_pkg::NBLK_W-1:0]      carve_left_q;
	logic [scfbp_pkg::BATCH_W-1:0]     want_q;
	logic [scfbp_pkg::BATCH_W-1:0]     rem_q;
	logic                              short_q;
	logic [31:0]                       rel_addr_q;

	// Output stage.
	logic                 out_valid_q;
	scfbp_pkg::out_word_t out_q;

	scfbp_pkg::mem_req_t  mem_req;
	logic [31:0]          mem_rdata;

	scfbp_stack_mem u_stack (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Shared combinational terms.
	logic                          accept;
	logic                          out_free;
	logic                          pool_full;
	logic [scfbp_pkg::BATCH_W-1:0] want_in;
	logic                          take_short;
	logic [32:0]                   chunk_end;
	logic                          chunk_fails;
	logic [31:0]                   block_size;
	logic [scfbp_pkg::CNT_W-1:0]   count_dec;
	logic                          avail_short;
	logic [scfbp_pkg::BATCH_W-1:0] avail;
	logic                          carving;

	// The input side is open only while the sequencer rests; the result register
	// still parts it from the output side, so a waiting result does not block intake.
	assign in_stall = (state_q != scfbp_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign pool_full = (count_q >= scfbp_pkg::DEPTH_CNT);
	assign count_dec = count_q - scfbp_pkg::CNT_W'(1);

	// A batch request is clipped to MAX_BATCH; a single take wants one block.
	always_comb begin
		if (in_word.func == scfbp_pkg::FUNC_TAKE) begin
			want_in = scfbp_pkg::BATCH_W'(1);
		end else if (in_word.batch_count > 7'(scfbp_pkg::MAX_BATCH)) begin
			want_in = scfbp_pkg::BATCH_W'(scfbp_pkg::MAX_BATCH);
		end else begin
			want_in = scfbp_pkg::BATCH_W'(in_word.batch_count);
		end
	end
	assign take_short = (count_q < scfbp_pkg::CNT_W'(want_in));

	// A chunk is carved only when it ends at or before heap_end, checked without wrap.
	assign chunk_end   = {1'b0, next_chunk_q} + 33'(scfbp_pkg::CHUNK_BYTES);
	assign chunk_fails = (chunk_end > {1'b0, heap_end_q});
	assign block_size  = 32'((32'(size_class_q) + 32'd1) * scfbp_pkg::ALIGN_BYTES);

	// Carving stops when the chunk runs out of blocks or the pool fills up; any
	// blocks left over are dropped.
	assign carving = (carve_left_q != '0) && !pool_full;

	assign avail_short = (count_q < scfbp_pkg::CNT_W'(want_q));
	assign avail       = avail_short ? scfbp_pkg::BATCH_W'(count_q) : want_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scfbp_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_word.func)
						scfbp_pkg::FUNC_RELEASE: state_d = scfbp_pkg::ST_REL;
						scfbp_pkg::FUNC_TAKE: begin
							state_d = take_short ? scfbp_pkg::ST_REFILL_CHK
								: scfbp_pkg::ST_POP_START;
						end
						scfbp_pkg::FUNC_BATCH: begin
							if (in_word.batch_count == '0) begin
								state_d = scfbp_pkg::ST_ZERO;
							end else if (take_short) begin
								state_d = scfbp_pkg::ST_REFILL_CHK;
							end else begin
								state_d = scfbp_pkg::ST_POP_START;
							end
						end
						default: state_d = scfbp_pkg::ST_IDLE;
					endcase
				end
			end
			scfbp_pkg::ST_REFILL_CHK: begin
				state_d = chunk_fails ? scfbp_pkg::ST_POP_START : scfbp_pkg::ST_REFILL;
			end
			scfbp_pkg::ST_REFILL: begin
				if (!carving) begin
					state_d = scfbp_pkg::ST_POP_START;
				end
			end
			scfbp_pkg::ST_POP_START: begin
				state_d = (avail == '0) ? scfbp_pkg::ST_FAIL : scfbp_pkg::ST_POP_RD;
			end
			scfbp_pkg::ST_POP_RD: state_d = scfbp_pkg::ST_POP_OUT;
			scfbp_pkg::ST_POP_OUT: begin
				if (out_free) begin
					if (rem_q != '0) begin
						state_d = scfbp_pkg::ST_POP_RD;
					end else if (short_q) begin
						state_d = scfbp_pkg::ST_FAIL;
					end else begin
						state_d = scfbp_pkg::ST_IDLE;
					end
				end
			end
			scfbp_pkg::ST_REL, scfbp_pkg::ST_ZERO, scfbp_pkg::ST_FAIL: begin
				if (out_free) begin
					state_d = scfbp_pkg::ST_IDLE;
				end
			end
			default: state_d = scfbp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory requests and the result to load.
	logic                        out_load;
	scfbp_pkg::out_word_t        out_d;
	logic [scfbp_pkg::CNT_W-1:0] count_after;

	always_comb begin
		mem_req     = '0;
		mem_req.waddr = count_q[scfbp_pkg::IDX_W-1:0];
		mem_req.raddr = count_dec[scfbp_pkg::IDX_W-1:0];
		out_load    = 1'b0;
		count_after = count_q;
		out_d                 = '0;
		out_d.status          = scfbp_pkg::STAT_OK;
		out_d.last            = 1'b1;
		case (state_q)
			scfbp_pkg::ST_REL: begin
				out_load      = out_free;
				mem_req.we    = out_free && !pool_full;
				mem_req.wdata = rel_addr_q;
				if (pool_full) begin
					out_d.status = scfbp_pkg::STAT_FULL;
				end else begin
					count_after = count_q + scfbp_pkg::CNT_W'(1);
				end
			end
			scfbp_pkg::ST_REFILL: begin
				mem_req.we    = carving;
				mem_req.wdata = carve_addr_q;
			end
			scfbp_pkg::ST_POP_RD: begin
				mem_req.re = 1'b1;
			end
			scfbp_pkg::ST_POP_OUT: begin
				out_load              = out_free;
				out_d.granted_address = mem_rdata;
				out_d.last            = (rem_q == '0) && !short_q;
			end
			scfbp_pkg::ST_FAIL: begin
				out_load     = out_free;
				out_d.status = scfbp_pkg::STAT_EXHAUSTED;
			end
			scfbp_pkg::ST_ZERO: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
		out_d.free_count = 11'(count_after);
		out_d.pool_empty = (count_after == '0);
	end

	// Sequencer state, configuration, pool count, carve pointer and batch counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= scfbp_pkg::ST_IDLE;
			size_class_q <= '0;
			heap_end_q   <= '0;
			next_chunk_q <= '0;
			count_q      <= '0;
			carve_left_q <= '0;
			want_q       <= '0;
			rem_q        <= '0;
			short_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					scfbp_pkg::CFG_SIZE_CLASS: size_class_q <= cfg_data[3:0];
					scfbp_pkg::CFG_HEAP_BASE:  next_chunk_q <= cfg_data;
					scfbp_pkg::CFG_HEAP_END:   heap_end_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				want_q <= want_in;
			end
			// A chunk that fits is claimed at once, even if it holds no whole block.
			if (state_q == scfbp_pkg::ST_REFILL_CHK && !chunk_fails) begin
				next_chunk_q <= chunk_end[31:0];
				carve_left_q <= scfbp_pkg::NBLK_W'(scfbp_pkg::CARVE_BLOCKS[size_class_q]);
			end
			if (state_q == scfbp_pkg::ST_REFILL && carving) begin
				carve_left_q <= carve_left_q - scfbp_pkg::NBLK_W'(1);
			end
			if (state_q == scfbp_pkg::ST_POP_START) begin
				rem_q   <= avail;
				short_q <= avail_short;
			end
			if (state_q == scfbp_pkg::ST_POP_RD) begin
				rem_q <= rem_q - scfbp_pkg::BATCH_W'(1);
			end
			if (mem_req.we) begin
				count_q <= count_q + scfbp_pkg::CNT_W'(1);
			end else if (mem_req.re) begin
				count_q <= count_dec;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			rel_addr_q <= in_word.block_address;
		end
		if (state_q == scfbp_pkg::ST_REFILL_CHK) begin
			carve_addr_q <= next_chunk_q;
		end else if (state_q == scfbp_pkg::ST_REFILL && carving) begin
			carve_addr_q <= carve_addr_q + block_size;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// Result register: a loaded word stays until the output side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= scfbp_pkg::DEPTH_CNT, "pool count above depth")
	`ASSERT_IMPL(a_no_write_full, clk, arst_n, mem_req.we, !pool_full, "stack written while full")
	`ASSERT_IMPL(a_pop_nonempty, clk, arst_n, state_q == scfbp_pkg::ST_POP_RD, count_q != '0, "pop from empty pool")
	`ASSERT_IMPL(a_not_last_ok, clk, arst_n, out_valid_q && !out_q.last, out_q.status == scfbp_pkg::STAT_OK, "non-final word with error status")
	`ASSERT_NEXT(a_release_path, clk, arst_n, accept && in_word.func == scfbp_pkg::FUNC_RELEASE, state_q == scfbp_pkg::ST_REL, "release not sequenced")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for size_class_free_block_pool_core: a directed table and
// random phases over several register settings. Depends on scfbp_pkg and the core RTL.

module tb_top;

	// Function code that the core must swallow without a result.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Quiet cycles after the last result before the registers are touched.
	localparam int SETTLE_CYCLES = 16;
	// One long receiver hold-off, so the core backs up and stalls its input.
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 60;
	localparam int TAIL_CYCLES = 64;
	localparam int LIMIT_NS = 20_000_000;
	localparam int MAX_REPORTS = 40;
	localparam int PHASE_WORDS = 30;

	typedef enum bit {ROW_REQ, ROW_REG} row_kind_t;

	// One line of the directed table: a request word, or a register write.
	typedef struct {
		row_kind_t             kind;
		scfbp_pkg::in_word_t   req;
		logic [1:0]            reg_idx;
		logic [31:0]           reg_val;
		bit                    fixed;
		scfbp_pkg::out_word_t  fixed_grant;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	scfbp_pkg::in_word_t  in_word;
	logic                 out_valid;
	logic                 out_stall;
	scfbp_pkg::out_word_t out_word;
	logic                 cfg_write;
	logic [1:0]           cfg_index;
	logic [31:0]          cfg_data;

	size_class_free_block_pool_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the pool: the free address stack, its fill count, the carve pointer
	// and the registers. It moves forward each time the core accepts a request word.
	logic [31:0] free_addr [scfbp_pkg::POOL_DEPTH];
	int unsigned free_cnt;
	logic [31:0] carve_ptr;
	logic [3:0]  cls_reg;
	logic [31:0] end_reg;

	// Result words the core still owes, oldest first.
	scfbp_pkg::out_word_t pending_grants [$];
	row_t                 script [$];

	bit send_idle;
	bit recv_idle;
	int words_sent;
	int grants_seen;
	int full_seen;
	int exhausted_seen;
	int reg_writes;
	int bad_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The whole run must fit well inside this; a hang ends here.
	initial begin
		#(LIMIT_NS);
		$display("size_class_free_block_pool_core: mismatch");
		$finish;
	end

	function automatic scfbp_pkg::in_word_t req(logic [1:0] func, logic [31:0] addr,
		logic [6:0] cnt);
		scfbp_pkg::in_word_t w;
		w.func = func;
		w.block_address = addr;
		w.batch_count = cnt;
		return w;
	endfunction

	function automatic void queue_grant(logic [31:0] addr, logic [1:0] st, logic last);
		scfbp_pkg::out_word_t g;
		g.granted_address = addr;
		g.status = st;
		g.last = last;
		g.free_count = 11'(free_cnt);
		g.pool_empty = (free_cnt == 0);
		pending_grants = {pending_grants, g};
	endfunction

	// Carve one chunk at the bump pointer, if it fits below heap_end. The bound check is
	// done in 64 bits so a chunk that would wrap past the top of the address space fails.
	function automatic void carve_chunk();
		longint unsigned bsz;
		longint unsigned nblk;
		longint unsigned start;
		longint unsigned i;
		bsz = (64'(cls_reg) + 1) * scfbp_pkg::ALIGN_BYTES;
		nblk = scfbp_pkg::CHUNK_BYTES / bsz;
		start = 64'(carve_ptr);
		if (start + scfbp_pkg::CHUNK_BYTES > 64'(end_reg))
			return;
		carve_ptr = 32'(start + scfbp_pkg::CHUNK_BYTES);
		for (i = 0; i < nblk; i++) begin
			if (free_cnt >= scfbp_pkg::POOL_DEPTH)
				break;
			free_addr[free_cnt] = 32'(start + i * bsz);
			free_cnt++;
		end
	endfunction

	// Work out the result words of one accepted request and queue them.
	function automatic void serve_request(scfbp_pkg::in_word_t w);
		int unsigned want;
		int unsigned avail;
		int unsigned i;
		case (w.func)
			scfbp_pkg::FUNC_RELEASE: begin
				if (free_cnt >= scfbp_pkg::POOL_DEPTH) begin
					queue_grant(32'd0, scfbp_pkg::STAT_FULL, 1'b1);
				end else begin
					free_addr[free_cnt] = w.block_address;
					free_cnt++;
					queue_grant(32'd0, scfbp_pkg::STAT_OK, 1'b1);
				end
			end
			scfbp_pkg::FUNC_TAKE: begin
				if (free_cnt == 0)
					carve_chunk();
				if (free_cnt == 0) begin
					queue_grant(32'd0, scfbp_pkg::STAT_EXHAUSTED, 1'b1);
				end else begin
					free_cnt--;
					queue_grant(free_addr[free_cnt], scfbp_pkg::STAT_OK, 1'b1);
				end
			end
			scfbp_pkg::FUNC_BATCH: begin
				want = w.batch_count;
				if (want == 0) begin
					queue_grant(32'd0, scfbp_pkg::STAT_OK, 1'b1);
				end else begin
					if (want > scfbp_pkg::MAX_BATCH)
						want = scfbp_pkg::MAX_BATCH;
					if (free_cnt < want)
						carve_chunk();
					avail = (free_cnt < want) ? free_cnt : want;
					for (i = 0; i < avail; i++) begin
						free_cnt--;
						queue_grant(free_addr[free_cnt], scfbp_pkg::STAT_OK,
							(avail == want) && (i + 1 == avail));
					end
					// A short batch closes with one exhausted word.
					if (avail < want)
						queue_grant(32'd0, scfbp_pkg::STAT_EXHAUSTED, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	// Mix of releases, single takes and batches with a little noise. Batch sizes are mostly
	// small; a tenth of them cover zero and the saturating range above MAX_BATCH.
	function automatic scfbp_pkg::in_word_t random_request();
		int pick;
		int spread;
		scfbp_pkg::in_word_t w;
		pick = $urandom_range(0, 99);
		spread = $urandom_range(0, 9);
		w = req(scfbp_pkg::FUNC_RELEASE, $urandom(), 7'($urandom_range(0, 127)));
		if (pick >= 35 && pick < 65) begin
			w.func = scfbp_pkg::FUNC_TAKE;
		end else if (pick >= 65 && pick < 95) begin
			w.func = scfbp_pkg::FUNC_BATCH;
			if (spread < 7)
				w.batch_count = 7'($urandom_range(1, 16));
			else if (spread < 9)
				w.batch_count = 7'($urandom_range(17, 64));
		end else if (pick >= 95) begin
			w.func = FUNC_UNUSED;
		end
		return w;
	endfunction

	function automatic void row_req(scfbp_pkg::in_word_t w, bit fixed,
		scfbp_pkg::out_word_t g);
		row_t r;
		r.kind = ROW_REQ;
		r.req = w;
		r.reg_idx = scfbp_pkg::CFG_SIZE_CLASS;
		r.reg_val = 32'd0;
		r.fixed = fixed;
		r.fixed_grant = g;
		script = {script, r};
	endfunction

	function automatic void row_reg(logic [1:0] idx, logic [31:0] val);
		row_t r;
		r.kind = ROW_REG;
		r.req = '0;
		r.reg_idx = idx;
		r.reg_val = val;
		r.fixed = 1'b0;
		r.fixed_grant = '0;
		script = {script, r};
	endfunction

	// Offer one request word, entered at a falling edge. The sender may first idle a few
	// cycles; once valid is up it stays up, with the word frozen, until the core takes it.
	// A typed-in result replaces the predicted one, while the shadow state still advances.
	task automatic push_word(scfbp_pkg::in_word_t w, bit fixed = 1'b0,
		scfbp_pkg::out_word_t g = '0);
		int gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
		serve_request(w);
		if (fixed)
			pending_grants[pending_grants.size() - 1] = g;
		words_sent++;
		@(negedge clk);
	endtask

	// Wait for the core to owe nothing, then give it time to finish an ignored word.
	task automatic settle();
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			scfbp_pkg::CFG_SIZE_CLASS: cls_reg = val[3:0];
			// Writing the base rewinds the carve pointer.
			scfbp_pkg::CFG_HEAP_BASE: carve_ptr = val;
			scfbp_pkg::CFG_HEAP_END: end_reg = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			bad_count++;
			if (bad_count <= MAX_REPORTS)
				$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_grant(scfbp_pkg::out_word_t got);
		scfbp_pkg::out_word_t want;
		grants_seen++;
		if (got.status == scfbp_pkg::STAT_FULL)
			full_seen++;
		if (got.status == scfbp_pkg::STAT_EXHAUSTED)
			exhausted_seen++;
		if (pending_grants.size() == 0) begin
			bad_count++;
			if (bad_count <= MAX_REPORTS)
				$display("%0t: result word expected none actual %h", $time, got);
			return;
		end
		want = pending_grants.pop_front();
		flag_field("granted_address", want.granted_address, got.granted_address);
		flag_field("status", 32'(want.status), 32'(got.status));
		flag_field("last", 32'(want.last), 32'(got.last));
		flag_field("free_count", 32'(want.free_count), 32'(got.free_count));
		flag_field("pool_empty", 32'(want.pool_empty), 32'(got.pool_empty));
	endtask

	// Receiver: before each result word it may hold stall for a few cycles, then waits
	// with stall low for the next valid word and checks it at that rising edge. Once, in a
	// phase where the sender offers words back to back, it holds off for a long stretch.
	initial begin : result_side
		int hold;
		bit held_once;
		held_once = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = recv_idle ? $urandom_range(0, 9) : 0;
			if (!held_once && words_sent >= HOLD_AFTER) begin
				held_once = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (out_valid !== 1'b1);
			check_grant(out_word);
		end
	end

	initial begin : request_side
		int ph;
		logic [31:0] base;
		logic [31:0] top;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b1;
		cfg_write = 1'b0;
		cfg_index = scfbp_pkg::CFG_SIZE_CLASS;
		cfg_data = 32'd0;
		arst_n = 1'b0;
		free_cnt = 0;
		carve_ptr = 32'd0;
		cls_reg = 4'd0;
		end_reg = 32'd0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		words_sent = 0;
		grants_seen = 0;
		full_seen = 0;
		exhausted_seen = 0;
		reg_writes = 0;
		bad_count = 0;

		// Directed table. Right after reset the heap is empty (base and end both zero),
		// so every carve fails and the results are obvious enough to type in.
		row_req(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0), 1'b1,
			'{32'd0, scfbp_pkg::STAT_EXHAUSTED, 1'b1, 11'd0, 1'b1});
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'hFFFF_FFFF, 7'd0), 1'b1,
			'{32'd0, scfbp_pkg::STAT_OK, 1'b1, 11'd0, 1'b1});
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd5), 1'b1,
			'{32'd0, scfbp_pkg::STAT_EXHAUSTED, 1'b1, 11'd0, 1'b1});
		row_req(req(FUNC_UNUSED, 32'hFFFF_FFFF, 7'd127), 1'b0, '0);
		row_req(req(scfbp_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 7'd127), 1'b1,
			'{32'd0, scfbp_pkg::STAT_OK, 1'b1, 11'd1, 1'b0});
		row_req(req(scfbp_pkg::FUNC_RELEASE, 32'd0, 7'd0), 1'b1,
			'{32'd0, scfbp_pkg::STAT_OK, 1'b1, 11'd2, 1'b0});
		row_req(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0), 1'b1,
			'{32'd0, scfbp_pkg::STAT_OK, 1'b1, 11'd1, 1'b0});
		// Saturates to MAX_BATCH and runs short: one address, then the exhausted word.
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd127), 1'b0, '0);
		// Largest class, one chunk just below the top of the address space.
		row_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'd15);
		row_reg(scfbp_pkg::CFG_HEAP_BASE, 32'hFFFF_E000);
		row_reg(scfbp_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
		row_req(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0), 1'b0, '0);
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd64), 1'b0, '0);
		// The next chunk would end exactly at 2^32, past heap_end, and must be refused.
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd1), 1'b1,
			'{32'd0, scfbp_pkg::STAT_EXHAUSTED, 1'b1, 11'd0, 1'b1});
		// Smallest class, a heap of two chunks from address zero.
		row_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'd0);
		row_reg(scfbp_pkg::CFG_HEAP_BASE, 32'd0);
		row_reg(scfbp_pkg::CFG_HEAP_END, 32'h0000_2000);
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd64), 1'b0, '0);
		row_req(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0), 1'b0, '0);
		row_req(req(scfbp_pkg::FUNC_BATCH, 32'd0, 7'd1), 1'b0, '0);
		row_req(req(scfbp_pkg::FUNC_RELEASE, 32'h1234_5678, 7'd64), 1'b1,
			'{32'd0, scfbp_pkg::STAT_OK, 1'b1, 11'd447, 1'b0});
		row_req(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0), 1'b0, '0);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[n]) begin
			if (script[n].kind == ROW_REG) begin
				in_valid <= 1'b0;
				settle();
				write_reg(script[n].reg_idx, script[n].reg_val);
			end else begin
				push_word(script[n].req, script[n].fixed, script[n].fixed_grant);
			end
		end

		// Random phases, each under its own register setting. Whatever the pool holds
		// carries over from one phase to the next.
		for (ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			settle();
			case (ph)
				0: begin
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'd0);
					write_reg(scfbp_pkg::CFG_HEAP_BASE, 32'd0);
					write_reg(scfbp_pkg::CFG_HEAP_END, 32'h0000_3000);
				end
				1: begin
					base = $urandom_range(0, 32'hFFF0_0000);
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'd15);
					write_reg(scfbp_pkg::CFG_HEAP_BASE, base);
					write_reg(scfbp_pkg::CFG_HEAP_END,
						base + 32'($urandom_range(0, 4)) * scfbp_pkg::CHUNK_BYTES);
				end
				2: begin
					// Nothing can be carved at the very top of the address space.
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'($urandom_range(0, 15)));
					write_reg(scfbp_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
					write_reg(scfbp_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'($urandom_range(0, 15)));
					write_reg(scfbp_pkg::CFG_HEAP_BASE, $urandom_range(0, 32'h7FFF_FFFF));
					write_reg(scfbp_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
				end
				4: begin
					// Only the end moves: carving resumes where the pointer stopped.
					top = (carve_ptr > 32'hFFFF_EFFF) ? 32'hFFFF_FFFF
						: carve_ptr + scfbp_pkg::CHUNK_BYTES;
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'($urandom_range(0, 15)));
					write_reg(scfbp_pkg::CFG_HEAP_END, top);
				end
				default: begin
					write_reg(scfbp_pkg::CFG_SIZE_CLASS, 32'd7);
					write_reg(scfbp_pkg::CFG_HEAP_BASE, 32'd0);
					write_reg(scfbp_pkg::CFG_HEAP_END, 32'd0);
				end
			endcase
			send_idle = (ph % 3 != 1);
			recv_idle = (ph % 3 != 2);
			repeat (PHASE_WORDS) push_word(random_request());
		end

		// One last take on the empty heap.
		send_idle = 1'b1;
		recv_idle = 1'b1;
		push_word(req(scfbp_pkg::FUNC_TAKE, 32'd0, 7'd0));
		in_valid <= 1'b0;

		// Let the last results drain, and watch a while longer for stray words.
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d request words and %0d register writes over empty and carved heaps.",
			words_sent, reg_writes);
		$display("Checked %0d result words: %0d pool full, %0d heap exhausted.",
			grants_seen, full_seen, exhausted_seen);
		if (bad_count == 0 && pending_grants.size() == 0) begin
			$display("size_class_free_block_pool_core: match");
		end else begin
			$display("size_class_free_block_pool_core: mismatch");
		end
		$finish;
	end

endmodule
